### sv/xrs_pkg.sv
// xrs_pkg: shared types, constants and helper functions for the xorshift128+ source
// holds request codes, unit status struct, hash constants and reset state words
// no dependencies
package xrs_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int DIV_W  = 63;
    localparam int DVS_W  = 33;
    localparam int CNT_W  = 6;

    localparam logic [WORD_W-1:0] MIX_A   = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] MIX_B   = 64'hc4ceb9fe1a85ec53;
    localparam logic [WORD_W-1:0] TOP_BIT = 64'h8000000000000000;

    localparam int MIX_SHIFT = 33;
    localparam int XS_SHL    = 23;
    localparam int XS_SHR_A  = 17;
    localparam int XS_SHR_B  = 26;

    typedef enum logic [2:0] {
        REQ_RAW    = 3'd0,
        REQ_LOW    = 3'd1,
        REQ_BELOW  = 3'd2,
        REQ_RANGE  = 3'd3,
        REQ_BOOL   = 3'd4,
        REQ_READ   = 3'd5,
        REQ_RESEED = 3'd6,
        REQ_NONE   = 3'd7
    } req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    function automatic logic [WORD_W-1:0] mix33(input logic [WORD_W-1:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

    // elaboration-time only, gives the reset state words
    function automatic logic [WORD_W-1:0] fmix64(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = mix33(x);
        y = y * MIX_A;
        y = mix33(y);
        y = y * MIX_B;
        y = mix33(y);
        return y;
    endfunction

    localparam logic [WORD_W-1:0] RST_FIRST  = fmix64(TOP_BIT);
    localparam logic [WORD_W-1:0] RST_SECOND = fmix64(RST_FIRST);

endpackage

### sv/xorshift128plus_random_source_core.sv
// xorshift128plus_random_source_core: xorshift128+ generator answering one request per item
// uses xrs_pkg, xrs_mul (reseed hash) and xrs_rem (bounded draws)
//
// usage
//   requests enter on the s_axis channel: tuser carries the request kind, tdata its
//   arguments. each request gives exactly one item on m_axis: tdata is the value,
//   tuser the zero-bound flag. the seed register is written with seed_we/seed_wdata
//   and is used by the next reseed request; the user must write it only while idle,
//   which the block itself does not enforce. one request is worked on at a time;
//   s_axis_tready is high only when idle. from accept to result valid: read state,
//   zero bound, empty range and unused codes go straight to the output step; raw,
//   low bits and boolean draws first draw from the generator; bounded and range
//   draws also wait on the bit-serial remainder unit, again for each rare
//   rejection retry; reseed runs four passes of the bit-serial multiplier.
//   a finished result sits in the output register; the next request is accepted
//   while it waits, and that request's result waits in turn until the receiver
//   takes the first one.
//   after reset the seed is 0 and the state words hold the hash of seed 0 (taken
//   as 2^63), as a reseed would give; no item is pending.
module xorshift128plus_random_source_core
    import xrs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seed_we,
    input  logic [63:0]   seed_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // bit_count[5:0], bound[37:6], range_low[69:38], range_high[101:70],
    // word_select[102], zero[103]
    input  logic [103:0]  s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // value[63:0]
    output logic [63:0]   m_axis_tdata,
    // bad_bound[0]
    output logic [0:0]    m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAW,
        S_BDRAW,
        S_BREM,
        S_BCHK,
        S_HSTART,
        S_HWAIT,
        S_OUT
    } state_t;

    state_t            state_reg;
    req_t              req_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVS_W-1:0]  n_reg;
    logic [HALF_W-1:0] lo_reg;
    logic [DIV_W-1:0]  d_reg;
    logic [WORD_W-1:0] work_reg;
    logic              mul_sel_reg;
    logic              pass_reg;
    logic [WORD_W-1:0] res_reg;
    logic              bad_reg;
    logic [WORD_W-1:0] first_reg;
    logic [WORD_W-1:0] second_reg;
    logic [WORD_W-1:0] seed_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;
    logic              out_bad_reg;

    req_t              in_req;
    logic [CNT_W-1:0]  in_cnt;
    logic [HALF_W-1:0] in_bound;
    logic [HALF_W-1:0] in_lo;
    logic [HALF_W-1:0] in_hi;
    logic              in_sel;
    logic              in_fire;

    logic [WORD_W-1:0] xs_a;
    logic [WORD_W-1:0] first_next;
    logic [WORD_W-1:0] second_next;
    logic [WORD_W-1:0] draw_val;
    logic [HALF_W-1:0] low_mask;
    logic [WORD_W-1:0] seed_eff;
    logic [WORD_W-1:0] chk;
    logic [WORD_W-1:0] mix_out;
    logic              slot_free;

    logic              mul_start;
    logic [WORD_W-1:0] mul_prod;
    unit_status_t      mul_st;
    logic              rem_start;
    logic [DVS_W-1:0]  rem_val;
    unit_status_t      rem_st;

    assign in_req   = req_t'(s_axis_tuser);
    assign in_cnt   = s_axis_tdata[5:0];
    assign in_bound = s_axis_tdata[37:6];
    assign in_lo    = s_axis_tdata[69:38];
    assign in_hi    = s_axis_tdata[101:70];
    assign in_sel   = s_axis_tdata[102];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // one xorshift128+ step
    assign xs_a        = first_reg ^ (first_reg << XS_SHL);
    assign first_next  = second_reg;
    assign second_next = xs_a ^ second_reg ^ (xs_a >> XS_SHR_A) ^ (second_reg >> XS_SHR_B);
    assign draw_val    = second_next + second_reg;

    assign low_mask = (cnt_reg >= CNT_W'(HALF_W)) ? '1 : ~({HALF_W{1'b1}} << cnt_reg[4:0]);
    assign seed_eff = (seed_reg == '0) ? TOP_BIT : seed_reg;

    // rejection test on d - v + n - 1
    assign chk = {1'b0, d_reg} - {{(WORD_W-DVS_W){1'b0}}, rem_val}
               + {{(WORD_W-DVS_W){1'b0}}, n_reg} - 64'd1;

    assign mix_out   = mix33(mul_prod);
    assign slot_free = !out_valid_reg || m_axis_tready;

    assign mul_start = (state_reg == S_HSTART);
    assign rem_start = (state_reg == S_BDRAW);

    xrs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (work_reg),
        .mplier  (mul_sel_reg ? MIX_B : MIX_A),
        .product (mul_prod),
        .status  (mul_st)
    );

    xrs_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (draw_val[WORD_W-1:1]),
        .divisor   (n_reg),
        .remainder (rem_val),
        .status    (rem_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= REQ_NONE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            lo_reg        <= '0;
            d_reg         <= '0;
            work_reg      <= '0;
            mul_sel_reg   <= 1'b0;
            pass_reg      <= 1'b0;
            res_reg       <= '0;
            bad_reg       <= 1'b0;
            first_reg     <= RST_FIRST;
            second_reg    <= RST_SECOND;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end

            if ((state_reg == S_OUT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_reg;
                out_bad_reg   <= bad_reg;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        req_reg <= in_req;
                        cnt_reg <= in_cnt;
                        bad_reg <= 1'b0;
                        res_reg <= '0;
                        case (in_req)
                            REQ_RAW, REQ_LOW, REQ_BOOL:
                            begin
                                state_reg <= S_DRAW;
                            end
                            REQ_BELOW:
                            begin
                                if (in_bound == '0)
                                begin
                                    bad_reg   <= 1'b1;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    n_reg     <= {1'b0, in_bound};
                                    lo_reg    <= '0;
                                    state_reg <= S_BDRAW;
                                end
                            end
                            REQ_RANGE:
                            begin
                                if (in_lo >= in_hi)
                                begin
                                    res_reg   <= {{(WORD_W-HALF_W){1'b0}}, in_lo};
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    n_reg     <= {1'b0, in_hi} - {1'b0, in_lo} + 33'd1;
                                    lo_reg    <= in_lo;
                                    state_reg <= S_BDRAW;
                                end
                            end
                            REQ_READ:
                            begin
                                res_reg   <= in_sel ? second_reg : first_reg;
                                state_reg <= S_OUT;
                            end
                            REQ_RESEED:
                            begin
                                work_reg    <= mix33(seed_eff);
                                mul_sel_reg <= 1'b0;
                                pass_reg    <= 1'b0;
                                state_reg   <= S_HSTART;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DRAW:
                begin
                    first_reg  <= first_next;
                    second_reg <= second_next;
                    case (req_reg)
                        REQ_LOW:
                        begin
                            res_reg <= {{(WORD_W-HALF_W){1'b0}}, draw_val[HALF_W-1:0] & low_mask};
                        end
                        REQ_BOOL:
                        begin
                            res_reg <= {{(WORD_W-1){1'b0}}, draw_val[0]};
                        end
                        default:
                        begin
                            res_reg <= draw_val;
                        end
                    endcase
                    state_reg <= S_OUT;
                end
                S_BDRAW:
                begin
                    first_reg  <= first_next;
                    second_reg <= second_next;
                    d_reg      <= draw_val[WORD_W-1:1];
                    state_reg  <= S_BREM;
                end
                S_BREM:
                begin
                    if (rem_st.done)
                    begin
                        state_reg <= S_BCHK;
                    end
                end
                S_BCHK:
                begin
                    if (chk[WORD_W-1])
                    begin
                        state_reg <= S_BDRAW;
                    end
                    else
                    begin
                        res_reg   <= {{(WORD_W-HALF_W){1'b0}}, lo_reg + rem_val[HALF_W-1:0]};
                        state_reg <= S_OUT;
                    end
                end
                S_HSTART:
                begin
                    state_reg <= S_HWAIT;
                end
                S_HWAIT:
                begin
                    if (mul_st.done)
                    begin
                        if (!mul_sel_reg)
                        begin
                            work_reg    <= mix_out;
                            mul_sel_reg <= 1'b1;
                            state_reg   <= S_HSTART;
                        end
                        else if (!pass_reg)
                        begin
                            first_reg   <= mix_out;
                            work_reg    <= mix33(mix_out);
                            mul_sel_reg <= 1'b0;
                            pass_reg    <= 1'b1;
                            state_reg   <= S_HSTART;
                        end
                        else
                        begin
                            second_reg <= mix_out;
                            state_reg  <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_bad_reg;

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_st.busy && rem_st.busy))
        else $error("multiplier and remainder unit busy together");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        rem_st.done |-> (rem_val < n_reg))
        else $error("remainder not below divisor");

    a_bad_bound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("zero-bound item carries a nonzero value");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("accepted item left the block idle");

endmodule

### sv/xrs_mul.sv
// xrs_mul: bit-serial 64x64 multiplier keeping the low 64 product bits
// one multiplier bit per cycle; depends on xrs_pkg
module xrs_mul
    import xrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] mcand,
    input  logic [WORD_W-1:0] mplier,
    output logic [WORD_W-1:0] product,
    output unit_status_t      status
);

    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            acc_reg  <= '0;
            a_reg    <= mcand;
            b_reg    <= mplier;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg   <= a_reg << 1;
            b_reg   <= b_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### sv/xrs_rem.sv
// xrs_rem: restoring remainder unit, 63-bit dividend by 33-bit divisor
// one dividend bit per cycle; depends on xrs_pkg
module xrs_rem
    import xrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVS_W-1:0] remainder,
    output unit_status_t     status
);

    logic [DIV_W-1:0] d_reg;
    logic [DVS_W-1:0] n_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, d_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, n_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg    <= '0;
            n_reg    <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            d_reg    <= dividend;
            n_reg    <= divisor;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor
            if (trial >= {1'b0, n_reg})
            begin
                rem_reg <= diff[DVS_W-1:0];
            end
            else
            begin
                rem_reg <= trial[DVS_W-1:0];
            end
            d_reg   <= d_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### tb/xorshift128plus_random_source_core_test.sv
// xorshift128plus_random_source_core_test: self-checking bench for the xorshift128+ source
// predicts every request result, checks the output stream field by field
// depends on xrs_pkg and xorshift128plus_random_source_core
module xorshift128plus_random_source_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import xrs_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_CHUNKS = 11;
    localparam int CHUNK_ITEMS   = 100;

    typedef struct {
        logic [63:0] value;
        logic        bad_bound;
    } draw_result_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          seed_we;
    logic [63:0]   seed_wdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata;
    logic [2:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [63:0]   m_axis_tdata;
    logic [0:0]    m_axis_tuser;

    draw_result_t  pending_draws[$];
    logic [63:0]   seed_copy;
    logic [63:0]   word_first;
    logic [63:0]   word_second;
    int            mismatches = 0;
    int            cycle_count = 0;
    bit            sender_gaps = 1'b0;
    bit            receiver_stalls = 1'b0;
    bit            hold_output = 1'b0;

    xorshift128plus_random_source_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_we       (seed_we),
        .seed_wdata    (seed_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] murmur_finish(input logic [63:0] x);
        logic [63:0] h;
        h = x ^ (x >> 33);
        h = h * MIX_A;
        h = h ^ (h >> 33);
        h = h * MIX_B;
        return h ^ (h >> 33);
    endfunction

    function automatic void rehash_words();
        word_first  = murmur_finish((seed_copy == 64'd0) ? TOP_BIT : seed_copy);
        word_second = murmur_finish(word_first);
    endfunction

    function automatic logic [63:0] step_words();
        logic [63:0] a;
        logic [63:0] b;
        a = word_first;
        b = word_second;
        word_first  = b;
        a           = a ^ (a << 23);
        word_second = a ^ b ^ (a >> 17) ^ (b >> 26);
        return word_second + b;
    endfunction

    // remainder of draw>>1 with the rejection test
    function automatic logic [63:0] draw_below(input logic [63:0] n);
        logic [63:0] d;
        logic [63:0] v;
        do
        begin
            d = step_words() >> 1;
            v = d % n;
        end
        while (((d - v + (n - 64'd1)) & TOP_BIT) != 64'd0);
        return v;
    endfunction

    function automatic draw_result_t predict_request(input req_t kind, input logic [5:0] count,
                                                     input logic [31:0] bnd,
                                                     input logic [31:0] lo,
                                                     input logic [31:0] hi, input logic sel);
        draw_result_t r;
        logic [63:0]  mask;
        r.value     = 64'd0;
        r.bad_bound = 1'b0;
        case (kind)
            REQ_RAW:
                r.value = step_words();
            REQ_LOW:
            begin
                mask    = (count >= 6'd32) ? 64'hffff_ffff : ((64'd1 << count) - 64'd1);
                r.value = step_words() & mask;
            end
            REQ_BELOW:
                if (bnd == 32'd0)
                    r.bad_bound = 1'b1;
                else
                    r.value = draw_below({32'd0, bnd}) & 64'hffff_ffff;
            REQ_RANGE:
                if (lo >= hi)
                    r.value = {32'd0, lo};
                else
                    r.value = ({32'd0, lo} + draw_below({32'd0, hi} - {32'd0, lo} + 64'd1))
                              & 64'hffff_ffff;
            REQ_BOOL:
                r.value = step_words() & 64'd1;
            REQ_READ:
                r.value = sel ? word_second : word_first;
            REQ_RESEED:
                rehash_words();
            default:
                r.value = 64'd0;
        endcase
        return r;
    endfunction

    task automatic send_request(input req_t kind, input logic [5:0] count,
                                input logic [31:0] bnd, input logic [31:0] lo,
                                input logic [31:0] hi, input logic sel);
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, sel, hi, lo, bnd, count};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_draws.push_back(predict_request(kind, count, bnd, lo, hi, sel));
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_kind(input req_t kind);
        send_request(kind, 6'($urandom), $urandom, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_draws.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] seed);
        seed_we    <= 1'b1;
        seed_wdata <= seed;
        @(posedge clk);
        seed_we    <= 1'b0;
        seed_copy   = seed;
    endtask

    task automatic send_random_request();
        int          pick;
        req_t        kind;
        logic [31:0] bnd;
        logic [31:0] lo;
        logic [31:0] hi;
        pick = $urandom_range(0, 99);
        if (pick < 15)      kind = REQ_RAW;
        else if (pick < 30) kind = REQ_LOW;
        else if (pick < 55) kind = REQ_BELOW;
        else if (pick < 75) kind = REQ_RANGE;
        else if (pick < 83) kind = REQ_BOOL;
        else if (pick < 91) kind = REQ_READ;
        else if (pick < 95) kind = REQ_RESEED;
        else                kind = REQ_NONE;
        case ($urandom_range(0, 9))
            0:       bnd = 32'd0;
            1, 2, 3: bnd = $urandom_range(1, 64);
            4:       bnd = 32'h8000_0000 | $urandom;
            default: bnd = $urandom;
        endcase
        lo = $urandom;
        case ($urandom_range(0, 5))
            0:       hi = lo;
            1:       hi = 32'hffff_ffff;
            2, 3:    hi = lo + $urandom_range(1, 100);
            default: hi = $urandom;
        endcase
        if ($urandom_range(0, 19) == 0)
            lo = 32'd0;
        send_request(kind, 6'($urandom), bnd, lo, hi, 1'($urandom));
    endtask

    task automatic test_each_request();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_kind(REQ_RAW);
        send_request(REQ_LOW, 6'd0, $urandom, $urandom, $urandom, 1'b0);
        send_request(REQ_LOW, 6'd1, $urandom, $urandom, $urandom, 1'b1);
        send_request(REQ_LOW, 6'd32, $urandom, $urandom, $urandom, 1'b0);
        send_request(REQ_LOW, 6'd33, $urandom, $urandom, $urandom, 1'b1);
        send_request(REQ_LOW, 6'd63, $urandom, $urandom, $urandom, 1'b0);
        send_request(REQ_BELOW, 6'd5, 32'd0, 32'd0, 32'd0, 1'b0);
        send_request(REQ_BELOW, 6'd5, 32'd1, 32'd0, 32'd0, 1'b0);
        send_request(REQ_BELOW, 6'd5, 32'd2, 32'd0, 32'd0, 1'b0);
        send_request(REQ_BELOW, 6'd5, 32'hffff_ffff, 32'd0, 32'd0, 1'b0);
        send_request(REQ_BELOW, 6'd5, 32'h8000_0000, 32'd0, 32'd0, 1'b0);
        send_request(REQ_RANGE, 6'd0, 32'd0, 32'd5, 32'd5, 1'b0);
        send_request(REQ_RANGE, 6'd0, 32'd0, 32'hffff_ffff, 32'd3, 1'b0);
        send_request(REQ_RANGE, 6'd0, 32'd0, 32'd0, 32'hffff_ffff, 1'b0);
        send_request(REQ_RANGE, 6'd0, 32'd0, 32'hffff_fffe, 32'hffff_ffff, 1'b0);
        send_request(REQ_RANGE, 6'd0, 32'd0, 32'd100, 32'd107, 1'b0);
        send_kind(REQ_BOOL);
        send_kind(REQ_BOOL);
        send_request(REQ_READ, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_request(REQ_READ, 6'h3f, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_kind(REQ_RESEED);
        send_request(REQ_READ, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_kind(REQ_NONE);
        send_request(REQ_READ, 6'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        wait_idle();
    endtask

    task automatic test_seed_values();
        logic [63:0] seeds[5];
        seeds = '{64'd0, 64'd1, 64'hffff_ffff_ffff_ffff, TOP_BIT,
                  {32'($urandom), 32'($urandom)}};
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            send_request(REQ_READ, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0);
            send_kind(REQ_RESEED);
            send_request(REQ_READ, 6'd0, 32'd0, 32'd0, 32'd0, 1'b0);
            send_request(REQ_READ, 6'd0, 32'd0, 32'd0, 32'd0, 1'b1);
            send_kind(REQ_RAW);
            send_request(REQ_BELOW, 6'd0, $urandom, 32'd0, 32'd0, 1'b0);
            wait_idle();
        end
    endtask

    task automatic test_output_backpressure();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_output     = 1'b1;
        repeat (12)
            send_kind(($urandom_range(0, 1) == 0) ? REQ_RAW : REQ_LOW);
        wait_idle();
    endtask

    task automatic test_random_requests();
        for (int c = 0; c < RANDOM_CHUNKS; c++)
        begin
            sender_gaps     = (c != RANDOM_CHUNKS - 1) && ($urandom_range(0, 3) != 0);
            receiver_stalls = (c != RANDOM_CHUNKS - 1) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0)
                write_seed({32'($urandom), 32'($urandom)});
            repeat (CHUNK_ITEMS)
                send_random_request();
            wait_idle();
        end
    endtask

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                hold_output    = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (receiver_stalls && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_draws.size() == 0)
            begin
                $error("unexpected item: value %h bad_bound %b", m_axis_tdata, m_axis_tuser[0]);
                mismatches++;
            end
            else
            begin
                want = pending_draws.pop_front();
                if (m_axis_tdata !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.bad_bound)
                begin
                    $error("bad_bound: expected %b, got %b", want.bad_bound, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        seed_we       <= 1'b0;
        seed_wdata    <= 64'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_NONE;
        seed_copy      = 64'd0;
        rehash_words();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_each_request();
        test_seed_values();
        test_output_backpressure();
        test_random_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
